/* rtl/b64e_pkg.sv */
package b64e_pkg;

  localparam logic [7:0] UPPER_BASE = 8'h41;  // 'A'
  localparam logic [7:0] LOWER_BASE = 8'h61;  // 'a'
  localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
  localparam logic [7:0] PLUS_CHAR  = 8'h2b;  // '+'
  localparam logic [7:0] SLASH_CHAR = 8'h2f;  // '/'
  localparam logic [7:0] PAD_CHAR   = 8'h3d;  // '='

  localparam logic [5:0] NUM_UPPER = 6'd26;
  localparam logic [5:0] NUM_ALPHA = 6'd52;
  localparam logic [5:0] NUM_ALNUM = 6'd62;
  localparam logic [5:0] CODE_PLUS = 6'd62;

  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_req_t;

  // One accepted byte turns into up to four characters, sent in index order.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            fin;
  } job_t;

  function automatic logic [7:0] sextet_char(logic [5:0] v);
    logic [7:0] c;
    if (v < NUM_UPPER) begin
      c = UPPER_BASE + {2'b00, v};
    end else if (v < NUM_ALPHA) begin
      c = LOWER_BASE + {2'b00, v - NUM_UPPER};
    end else if (v < NUM_ALNUM) begin
      c = DIGIT_BASE + {2'b00, v - NUM_ALPHA};
    end else if (v == CODE_PLUS) begin
      c = PLUS_CHAR;
    end else begin
      c = SLASH_CHAR;
    end
    return c;
  endfunction

endpackage

/* rtl/b64e_front.sv */
module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  b64e_pkg::in_req_t in_req_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output b64e_pkg::job_t   push_job_o
);

  b64e_pkg::phase_e phase_q, phase_d;
  logic [3:0]       res_q, res_d;
  logic             accept;
  logic [7:0]       b;
  b64e_pkg::job_t   job;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;
  assign b            = in_req_i.data_byte;
  assign push_job_o   = job;

  always_comb begin
    phase_d      = phase_q;
    res_d        = res_q;
    job.chars    = '{default: b64e_pkg::PAD_CHAR};
    job.last_idx = 2'd0;
    job.fin      = in_req_i.last_byte;
    unique case (phase_q)
      b64e_pkg::PH_1: begin
        job.chars[0] = b64e_pkg::sextet_char({res_q[1:0], b[7:4]});
        if (in_req_i.last_byte) begin
          job.chars[1] = b64e_pkg::sextet_char({b[3:0], 2'b00});
          job.last_idx = 2'd2;
          res_d        = 4'd0;
          phase_d      = b64e_pkg::PH_0;
        end else begin
          res_d   = b[3:0];
          phase_d = b64e_pkg::PH_2;
        end
      end
      b64e_pkg::PH_2: begin
        job.chars[0] = b64e_pkg::sextet_char({res_q, b[7:6]});
        job.chars[1] = b64e_pkg::sextet_char(b[5:0]);
        job.last_idx = 2'd1;
        res_d        = 4'd0;
        phase_d      = b64e_pkg::PH_0;
      end
      default: begin
        job.chars[0] = b64e_pkg::sextet_char(b[7:2]);
        if (in_req_i.last_byte) begin
          job.chars[1] = b64e_pkg::sextet_char({b[1:0], 4'b0000});
          job.last_idx = 2'd3;
          res_d        = 4'd0;
          phase_d      = b64e_pkg::PH_0;
        end else begin
          res_d   = {2'b00, b[1:0]};
          phase_d = b64e_pkg::PH_1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= b64e_pkg::PH_0;
      res_q   <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      res_q   <= res_d;
    end
  end

  // end of message always returns to a clean group start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_req_i.last_byte) |=> (phase_q == b64e_pkg::PH_0 && res_q == 4'd0))
    else $error("group state not cleared after last byte");

endmodule

/* rtl/b64e_fifo.sv */
module b64e_fifo #(
  parameter int Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  b64e_pkg::job_t push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output b64e_pkg::job_t pop_job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  b64e_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

/* rtl/b64e_back.sv */
module b64e_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  b64e_pkg::job_t     pop_job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output b64e_pkg::out_req_t out_req_o
);

  b64e_pkg::job_t     cur_q;
  logic               busy_q;
  logic [1:0]         idx_q;
  logic               out_valid_q;
  b64e_pkg::out_req_t out_q;
  logic               load;      // output register takes a character
  logic               at_end;
  logic               take;

  assign load        = busy_q & (~out_valid_q | out_ready_i);
  assign at_end      = (idx_q == cur_q.last_idx);
  assign pop_ready_o = ~busy_q | (load & at_end);
  assign take        = pop_valid_i & pop_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= pop_job_i;
    end
    if (load) begin
      out_q.out_char  <= cur_q.chars[idx_q];
      out_q.last_char <= cur_q.fin & at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        idx_q  <= 2'd0;
      end else if (load) begin
        busy_q <= ~at_end;
        idx_q  <= idx_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // a flagged last character closes the job unless a new one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && cur_q.fin && at_end && !pop_valid_i) |=> !busy_q)
    else $error("serializer still busy after last character");

endmodule

/* rtl/base64_encoder_top.sv */
// Streaming base64 encoder, standard alphabet with '=' padding. Send one
// message byte per request on the input channel and raise last_byte on the
// final byte; the output channel returns ASCII characters one per request,
// with last_char set on the final character of the message (after any '='
// padding). A message with a last byte always leaves the encoder at the start
// of a fresh group. Rate: the input takes one byte per cycle while the job
// queue between the byte classifier and the character serializer has room
// (QueueDepth entries); the serializer sends one character per cycle while
// the output is ready, so a steady stream gives four characters per three
// bytes; a final byte yields up to four characters. Output characters are
// registered, behind the job queue and the serializer's job register.
module base64_encoder_top #(
  parameter int QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  b64e_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output b64e_pkg::out_req_t out_req_o
);

  // front to queue
  logic           push_valid;
  logic           push_ready;
  b64e_pkg::job_t push_job;
  // queue to back
  logic           pop_valid;
  logic           pop_ready;
  b64e_pkg::job_t pop_job;

  // Tracks group phase and leftover bits, turns each byte into a character job.
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Decouples byte intake from character output.
  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // Sends the characters of each job one per cycle, while the output is ready, through an output register.
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule
